// ----- rtl/prtt_pkg.sv -----
// Shared widths, constants, codes and status types for the PPS-referenced trigger timestamp block.
package prtt_pkg;

    localparam int FRAME_W  = 24;
    localparam int PFRAME_W = 26;
    localparam int SAMPLE_W = 12;
    localparam int REM_W    = 3;
    localparam int SEC_W    = 32;
    localparam int FTM_W    = 16;
    localparam int FREQ_W   = 27;
    localparam int ROLL_W   = 8;
    localparam int TS_W     = 64;

    // Tick count of one time and its split into two halves for the scaling multiply.
    localparam int TICK_W   = 42;
    localparam int HALF_W   = TICK_W / 2;
    localparam int NS_W     = 30;
    localparam int PROD_W   = HALF_W + NS_W;
    localparam int DVD_W    = TICK_W + NS_W;
    localparam int CNT_W    = $clog2(DVD_W);

    localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FTM  = 1'b0,
        CFG_FREQ = 1'b1
    } t_cfg_idx;

    // Request kinds carried in the input user field.
    typedef enum logic [0:0] {
        MODE_PPS  = 1'b0,
        MODE_TRIG = 1'b1
    } t_mode;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ----- rtl/prtt_scale.sv -----
// Converts a frame, sample and remainder time into ticks times one billion in the steps ADD, LO, HI and SUM.
module prtt_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [prtt_pkg::PFRAME_W-1:0]     i_frame,
    input  logic [prtt_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [prtt_pkg::REM_W-1:0]        i_remainder,
    input  logic [prtt_pkg::FTM_W-1:0]        i_frame_ticks_minus_one,
    output prtt_pkg::t_unit_sts               o_sts,
    output logic [prtt_pkg::DVD_W-1:0]        o_dividend
);

    localparam int FT_W   = prtt_pkg::FTM_W + 1;
    localparam int MUL_W  = prtt_pkg::PFRAME_W + FT_W;
    localparam int LOW_W  = prtt_pkg::SAMPLE_W + 3;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_ADD,
        SC_LO,
        SC_HI,
        SC_SUM
    } t_stage;

    t_stage                            r_stage;
    logic                              r_done;
    logic [prtt_pkg::TICK_W-1:0]       r_prod;
    logic [LOW_W-1:0]                  r_low;
    logic [prtt_pkg::TICK_W-1:0]       r_ticks;
    logic [prtt_pkg::PROD_W-1:0]       r_plo;
    logic [prtt_pkg::PROD_W-1:0]       r_phi;
    logic [prtt_pkg::DVD_W-1:0]        r_dvd;

    logic [FT_W-1:0]                   w_ft;
    logic [MUL_W-1:0]                  w_mul;
    logic [prtt_pkg::PROD_W-1:0]       w_plo;
    logic [prtt_pkg::PROD_W-1:0]       w_phi;

    always_comb begin
        w_ft  = {1'b0, i_frame_ticks_minus_one} + FT_W'(1);
        w_mul = {{FT_W{1'b0}}, i_frame} * {{prtt_pkg::PFRAME_W{1'b0}}, w_ft};
        w_plo = {{prtt_pkg::NS_W{1'b0}}, r_ticks[prtt_pkg::HALF_W-1:0]}
              * {{prtt_pkg::HALF_W{1'b0}}, prtt_pkg::NS_PER_S};
        w_phi = {{prtt_pkg::NS_W{1'b0}}, r_ticks[prtt_pkg::TICK_W-1:prtt_pkg::HALF_W]}
              * {{prtt_pkg::HALF_W{1'b0}}, prtt_pkg::NS_PER_S};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= SC_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // The product stays below 2^42 for every field value.
                r_prod  <= w_mul[prtt_pkg::TICK_W-1:0];
                r_low   <= {i_sample, 3'b000} + LOW_W'(i_remainder);
                r_stage <= SC_ADD;
            end else begin
                unique case (r_stage)
                    SC_IDLE: begin
                        r_stage <= SC_IDLE;
                    end
                    SC_ADD: begin
                        r_ticks <= r_prod + prtt_pkg::TICK_W'(r_low);
                        r_stage <= SC_LO;
                    end
                    SC_LO: begin
                        r_plo   <= w_plo;
                        r_stage <= SC_HI;
                    end
                    SC_HI: begin
                        r_phi   <= w_phi;
                        r_stage <= SC_SUM;
                    end
                    SC_SUM: begin
                        r_dvd   <= {r_phi, {prtt_pkg::HALF_W{1'b0}}}
                                 + prtt_pkg::DVD_W'(r_plo);
                        r_done  <= 1'b1;
                        r_stage <= SC_IDLE;
                    end
                    default: begin
                        r_stage <= SC_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_sts.busy = (r_stage != SC_IDLE);
    assign o_sts.done = r_done;
    assign o_dividend = r_dvd;

endmodule

// ----- rtl/prtt_div.sv -----
// Bit-serial restoring divider: one dividend bit per cycle, low 64 quotient bits kept.
module prtt_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [prtt_pkg::DVD_W-1:0]        i_dividend,
    input  logic [prtt_pkg::FREQ_W-1:0]       i_divisor,
    output prtt_pkg::t_unit_sts               o_sts,
    output logic [prtt_pkg::TS_W-1:0]         o_quotient
);

    logic                              r_busy;
    logic                              r_done;
    logic [prtt_pkg::CNT_W-1:0]        r_cnt;
    logic [prtt_pkg::DVD_W-1:0]        r_dvd;
    logic [prtt_pkg::FREQ_W-1:0]       r_div;
    logic [prtt_pkg::FREQ_W-1:0]       r_rem;
    logic [prtt_pkg::TS_W-1:0]         r_quo;

    logic [prtt_pkg::FREQ_W:0]         w_trial;
    logic [prtt_pkg::FREQ_W:0]         w_diff;
    logic                              w_ge;
    logic [prtt_pkg::FREQ_W-1:0]       n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[prtt_pkg::DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        // The partial remainder stays below the divisor, so it fits the divisor width.
        n_rem   = w_ge ? w_diff[prtt_pkg::FREQ_W-1:0] : w_trial[prtt_pkg::FREQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[prtt_pkg::DVD_W-2:0], 1'b0};
                r_rem <= n_rem;
                r_quo <= {r_quo[prtt_pkg::TS_W-2:0], w_ge};
                r_cnt <= r_cnt + prtt_pkg::CNT_W'(1);
                if (r_cnt == prtt_pkg::CNT_W'(prtt_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/pps_referenced_trigger_timestamp.sv -----
// Top level of the PPS-referenced trigger timestamp block: control, frame repair and flags.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: time fields, tuser: mode
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: timestamp, frame, tuser: flags
//  cfg       in         i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// A PPS update is taken while idle and gives no result. A trigger loads its result after it
// is accepted and passes through these steps: scaling of the trigger time, two passes through
// the shared bit-serial divider over the 72 dividend bits (trigger time, then the PPS time
// scaled meanwhile) and four offset and flag steps; the next request is taken back in idle.
// Reset is synchronous and clears the reference state, the counters and the output valid.
// A finished trigger holds in its last step only while the output register is still full.
module pps_referenced_trigger_timestamp (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [23:0] frame, [35:24] sample, [38:36] remainder, [70:39] wall_second, [71] zero
    input  logic [71:0]  s_axis_tdata,
    // [0] mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] timestamp_ns, [95:64] corrected_frame
    output logic [95:0]  m_axis_tdata,
    // [0] rollover_fixed, [1] warn_backward, [2] warn_forward, [3] warn_near_pps
    output logic [3:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_idx,
    input  logic [26:0]  i_cfg_data
);

    localparam int TS_W  = prtt_pkg::TS_W;
    localparam int DLT_W = TS_W + 1;
    localparam int SNS_W = prtt_pkg::SEC_W + prtt_pkg::NS_W;

    localparam logic [prtt_pkg::FTM_W-1:0]    FTM_RESET  = 16'd20479;
    localparam logic [prtt_pkg::FREQ_W-1:0]   FREQ_RESET = 27'd15999907;
    localparam logic [prtt_pkg::PFRAME_W-1:0] WRAP_TOL   = 26'd16770000;
    localparam logic [prtt_pkg::PFRAME_W-1:0] FRAME_WRAP = 26'd16777216;
    localparam logic signed [DLT_W-1:0]       BACK_LIM   = 65'sd1000000000;
    localparam logic signed [DLT_W-1:0]       FWD_LIM    = -65'sd20000000000;
    localparam logic signed [TS_W-1:0]        NEAR_LIM   = 64'sd1000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_START,
        S_T_SCALE,
        S_T_DIV,
        S_P_DIV,
        S_OFFSET,
        S_TS,
        S_DIFF,
        S_FLAGS
    } t_state;

    t_state                              r_state;
    logic [prtt_pkg::FTM_W-1:0]          r_ftm;
    logic [prtt_pkg::FREQ_W-1:0]         r_freq;

    logic [prtt_pkg::PFRAME_W-1:0]       r_pps_frame;
    logic [prtt_pkg::SAMPLE_W-1:0]       r_pps_sample;
    logic [prtt_pkg::REM_W-1:0]          r_pps_rem;
    logic [prtt_pkg::SEC_W-1:0]          r_pps_sec;
    logic [prtt_pkg::ROLL_W-1:0]         r_roll;
    logic [prtt_pkg::FRAME_W-1:0]        r_last_frame;
    logic [TS_W-1:0]                     r_last_ts;

    logic [prtt_pkg::PFRAME_W-1:0]       r_tframe;
    logic [prtt_pkg::SAMPLE_W-1:0]       r_tsample;
    logic [prtt_pkg::REM_W-1:0]          r_trem;
    logic [31:0]                         r_corr;
    logic                                r_fixed;
    logic [TS_W-1:0]                     r_tt;
    logic [TS_W-1:0]                     r_tp;
    logic [TS_W-1:0]                     r_off;
    logic [SNS_W-1:0]                    r_secns;
    logic [TS_W-1:0]                     r_ts;
    logic [DLT_W-1:0]                    r_dlt;

    logic                                r_out_valid;
    logic [95:0]                         r_out_data;
    logic [3:0]                          r_out_user;

    logic [prtt_pkg::FRAME_W-1:0]        w_frame;
    logic [prtt_pkg::SAMPLE_W-1:0]       w_sample;
    logic [prtt_pkg::REM_W-1:0]          w_rem;
    logic [prtt_pkg::SEC_W-1:0]          w_wsec;
    logic                                w_accept;
    logic                                w_lt_pps;
    logic [prtt_pkg::PFRAME_W-1:0]       w_fdiff;
    logic                                w_fixed;
    logic [prtt_pkg::ROLL_W-1:0]         w_roll;
    logic [SNS_W-1:0]                    w_secns;
    logic                                w_out_free;
    logic                                w_out_load;
    logic                                w_last_pos;

    logic                                w_scale_start;
    logic [prtt_pkg::PFRAME_W-1:0]       w_sc_frame;
    logic [prtt_pkg::SAMPLE_W-1:0]       w_sc_sample;
    logic [prtt_pkg::REM_W-1:0]          w_sc_rem;
    prtt_pkg::t_unit_sts                 w_scale_sts;
    logic [prtt_pkg::DVD_W-1:0]          w_dividend;

    logic                                w_div_start;
    logic [prtt_pkg::FREQ_W-1:0]         w_divisor;
    prtt_pkg::t_unit_sts                 w_div_sts;
    logic [TS_W-1:0]                     w_quotient;

    always_comb begin
        w_frame    = s_axis_tdata[23:0];
        w_sample   = s_axis_tdata[35:24];
        w_rem      = s_axis_tdata[38:36];
        w_wsec     = s_axis_tdata[70:39];
        w_accept   = s_axis_tvalid && s_axis_tready;

        w_lt_pps   = ({2'b00, w_frame} < r_pps_frame);
        w_fdiff    = w_lt_pps ? (r_pps_frame - {2'b00, w_frame})
                              : ({2'b00, w_frame} - r_pps_frame);
        w_fixed    = (w_fdiff > WRAP_TOL);
        w_roll     = (w_frame < r_last_frame) ? (r_roll + prtt_pkg::ROLL_W'(1)) : r_roll;

        w_secns    = {{prtt_pkg::NS_W{1'b0}}, r_pps_sec}
                   * {{prtt_pkg::SEC_W{1'b0}}, prtt_pkg::NS_PER_S};
        w_out_free = !r_out_valid || m_axis_tready;
        w_out_load = (r_state == S_FLAGS) && w_out_free;
        w_last_pos = !r_last_ts[TS_W-1] && (r_last_ts != '0);

        // The PPS time is scaled while the divider works on the trigger time.
        w_scale_start = (r_state == S_T_START) || ((r_state == S_T_SCALE) && w_scale_sts.done);
        w_sc_frame    = (r_state == S_T_START) ? r_tframe  : r_pps_frame;
        w_sc_sample   = (r_state == S_T_START) ? r_tsample : r_pps_sample;
        w_sc_rem      = (r_state == S_T_START) ? r_trem    : r_pps_rem;

        w_div_start   = ((r_state == S_T_SCALE) && w_scale_sts.done)
                     || ((r_state == S_T_DIV) && w_div_sts.done);
        w_divisor     = (r_freq == '0) ? prtt_pkg::FREQ_W'(1) : r_freq;
    end

    prtt_scale u_scale (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_start                 (w_scale_start),
        .i_frame                 (w_sc_frame),
        .i_sample                (w_sc_sample),
        .i_remainder             (w_sc_rem),
        .i_frame_ticks_minus_one (r_ftm),
        .o_sts                   (w_scale_sts),
        .o_dividend              (w_dividend)
    );

    prtt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_div_sts),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ftm        <= FTM_RESET;
            r_freq       <= FREQ_RESET;
            r_pps_frame  <= '0;
            r_pps_sample <= '0;
            r_pps_rem    <= '0;
            r_pps_sec    <= '0;
            r_roll       <= '0;
            r_last_frame <= '0;
            r_last_ts    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (prtt_pkg::t_cfg_idx'(i_cfg_idx))
                    prtt_pkg::CFG_FTM:  r_ftm  <= i_cfg_data[prtt_pkg::FTM_W-1:0];
                    prtt_pkg::CFG_FREQ: r_freq <= i_cfg_data;
                    default:            r_ftm  <= r_ftm;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser == prtt_pkg::MODE_PPS) begin
                            r_pps_frame  <= {2'b00, w_frame};
                            r_pps_sample <= w_sample;
                            r_pps_rem    <= w_rem;
                            r_pps_sec    <= w_wsec;
                        end else begin
                            r_roll       <= w_roll;
                            r_last_frame <= w_frame;
                            r_corr       <= {w_roll, w_frame};
                            r_fixed      <= w_fixed;
                            r_tsample    <= w_sample;
                            r_trem       <= w_rem;
                            // A wrap is repaired on the trigger side when it is behind,
                            // otherwise the stored PPS frame takes the shift for good.
                            if (w_fixed && w_lt_pps) begin
                                r_tframe <= {2'b00, w_frame} + FRAME_WRAP;
                            end else begin
                                r_tframe <= {2'b00, w_frame};
                            end
                            if (w_fixed && !w_lt_pps) begin
                                r_pps_frame <= r_pps_frame + FRAME_WRAP;
                            end
                            r_state <= S_T_START;
                        end
                    end
                end
                S_T_START: begin
                    r_state <= S_T_SCALE;
                end
                S_T_SCALE: begin
                    if (w_scale_sts.done) begin
                        r_state <= S_T_DIV;
                    end
                end
                S_T_DIV: begin
                    if (w_div_sts.done) begin
                        r_tt    <= w_quotient;
                        r_state <= S_P_DIV;
                    end
                end
                S_P_DIV: begin
                    if (w_div_sts.done) begin
                        r_tp    <= w_quotient;
                        r_state <= S_OFFSET;
                    end
                end
                S_OFFSET: begin
                    r_off   <= r_tt - r_tp;
                    r_secns <= w_secns;
                    r_state <= S_TS;
                end
                S_TS: begin
                    r_ts    <= TS_W'(r_secns) + r_off;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    // Exact signed difference, previous minus current.
                    r_dlt   <= {r_last_ts[TS_W-1], r_last_ts} - {r_ts[TS_W-1], r_ts};
                    r_state <= S_FLAGS;
                end
                S_FLAGS: begin
                    if (w_out_free) begin
                        r_out_data    <= {r_corr, r_ts};
                        r_out_user[0] <= r_fixed;
                        r_out_user[1] <= ($signed(r_dlt) > BACK_LIM);
                        r_out_user[2] <= w_last_pos && ($signed(r_dlt) < FWD_LIM);
                        r_out_user[3] <= ($signed(r_off) < NEAR_LIM);
                        r_last_ts     <= r_ts;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_result_from_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_FLAGS))
        else $error("result appeared outside the flag step");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_T_DIV || r_state == S_P_DIV))
        else $error("divider finished outside a division step");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_sts.busy)
        else $error("divider busy while the block is idle");

    a_trigger_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == prtt_pkg::MODE_TRIG))
        |=> !s_axis_tready)
        else $error("request taken while a trigger is in progress");

endmodule

// ----- tb/tb_pps_referenced_trigger_timestamp.sv -----
// Self-checking testbench for the PPS-referenced trigger timestamp block.
module tb_pps_referenced_trigger_timestamp;

    typedef longint unsigned t_u64;

    localparam int FLAG_FIXED = 0;
    localparam int FLAG_BACK  = 1;
    localparam int FLAG_FWD   = 2;
    localparam int FLAG_NEAR  = 3;

    localparam logic [prtt_pkg::PFRAME_W-1:0] FRAME_SPAN = 26'd16777216;
    localparam longint WRAP_TOL         = 16770000;
    localparam longint NEAR_NS          = 1000;
    localparam t_u64   NS_PER_SEC       = 64'd1000000000;
    localparam t_u64   FWD_LIMIT        = 64'd20000000000;
    localparam t_u64   TICKS_PER_SAMPLE = 64'd8;

    typedef struct packed {
        logic                          mode;
        logic [prtt_pkg::FRAME_W-1:0]  frame;
        logic [prtt_pkg::SAMPLE_W-1:0] sample;
        logic [prtt_pkg::REM_W-1:0]    rem;
        logic [prtt_pkg::SEC_W-1:0]    wsec;
    } t_time_req;

    typedef struct packed {
        logic [prtt_pkg::TS_W-1:0] stamp;
        logic [31:0]               corr;
        logic [3:0]                flags;
    } t_stamp;

    class t_stamp_board;
        logic [prtt_pkg::FTM_W-1:0]    ticks_m1;
        logic [prtt_pkg::FREQ_W-1:0]   freq_hz;
        logic [prtt_pkg::PFRAME_W-1:0] ref_frame;
        logic [prtt_pkg::SAMPLE_W-1:0] ref_sample;
        logic [prtt_pkg::REM_W-1:0]    ref_rem;
        logic [prtt_pkg::SEC_W-1:0]    ref_second;
        logic [prtt_pkg::ROLL_W-1:0]   rolls;
        logic [prtt_pkg::FRAME_W-1:0]  prev_frame;
        longint                        prev_stamp;
        t_stamp                        waiting[$];
        int                            errors;
        string                         flag_name[4] = '{"rollover_fixed", "warn_backward",
                                                        "warn_forward", "warn_near_pps"};

        function new();
            ticks_m1   = 16'd20479;
            freq_hz    = 27'd15999907;
            ref_frame  = '0;
            ref_sample = '0;
            ref_rem    = '0;
            ref_second = '0;
            rolls      = '0;
            prev_frame = '0;
            prev_stamp = 0;
            errors     = 0;
        endfunction

        function void write_reg(prtt_pkg::t_cfg_idx idx, logic [prtt_pkg::FREQ_W-1:0] val);
            if (idx == prtt_pkg::CFG_FTM) begin
                ticks_m1 = val[prtt_pkg::FTM_W-1:0];
            end else begin
                freq_hz = val;
            end
        endfunction

        // Exact floor(ticks * 1e9 / f), split so that no product leaves 64 bits.
        function t_u64 to_ns(t_u64 frm, t_u64 smp, t_u64 rm);
            t_u64 div, ticks;
            div   = (freq_hz == '0) ? 64'd1 : t_u64'(freq_hz);
            ticks = frm * (t_u64'(ticks_m1) + 64'd1) + smp * TICKS_PER_SAMPLE + rm;
            return (ticks / div) * NS_PER_SEC + ((ticks % div) * NS_PER_SEC) / div;
        endfunction

        function void note_request(t_time_req r);
            longint                        fdiff;
            logic [prtt_pkg::PFRAME_W-1:0] trig_frame;
            t_u64                          t_trig, t_ref, lapse;
            longint                        offset, stamp;
            t_stamp                        want;
            if (r.mode == prtt_pkg::MODE_PPS) begin
                ref_frame  = {2'b00, r.frame};
                ref_sample = r.sample;
                ref_rem    = r.rem;
                ref_second = r.wsec;
                return;
            end
            fdiff = longint'(r.frame) - longint'(ref_frame);
            if (fdiff < 0) fdiff = -fdiff;
            if (r.frame < prev_frame) rolls = rolls + prtt_pkg::ROLL_W'(1);
            want.corr  = {rolls, r.frame};
            want.flags = '0;
            trig_frame = {2'b00, r.frame};
            want.flags[FLAG_FIXED] = fdiff > WRAP_TOL;
            // The trigger side is shifted for this item only; a shifted PPS frame sticks.
            if (want.flags[FLAG_FIXED]) begin
                if ({2'b00, r.frame} < ref_frame) trig_frame = {2'b00, r.frame} + FRAME_SPAN;
                else ref_frame = ref_frame + FRAME_SPAN;
            end
            t_trig = to_ns(t_u64'(trig_frame), t_u64'(r.sample), t_u64'(r.rem));
            t_ref  = to_ns(t_u64'(ref_frame), t_u64'(ref_sample), t_u64'(ref_rem));
            offset = longint'(t_trig - t_ref);
            stamp  = longint'(t_u64'(ref_second) * NS_PER_SEC + t_u64'(offset));
            lapse  = t_u64'(prev_stamp - stamp);
            want.flags[FLAG_BACK] = (stamp < prev_stamp) && (lapse > NS_PER_SEC);
            lapse  = t_u64'(stamp - prev_stamp);
            want.flags[FLAG_FWD]  = (prev_stamp > 0) && (stamp > prev_stamp)
                                    && (lapse > FWD_LIMIT);
            want.flags[FLAG_NEAR] = offset < NEAR_NS;
            want.stamp = stamp;
            prev_stamp = stamp;
            prev_frame = r.frame;
            waiting.insert(waiting.size(), want);
        endfunction

        function void miss(string what, t_u64 want, t_u64 got);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        endfunction

        function void check_stamp(logic [prtt_pkg::TS_W-1:0] stamp, logic [31:0] corr,
                                  logic [3:0] flags);
            t_stamp want;
            if (waiting.size() == 0) begin
                errors++;
                $display("%0t: result with no trigger pending, expected none, actual %h %h %h",
                         $time, stamp, corr, flags);
                return;
            end
            want = waiting.pop_front();
            if (stamp !== want.stamp) miss("timestamp_ns", want.stamp, stamp);
            if (corr !== want.corr) miss("corrected_frame", t_u64'(want.corr), t_u64'(corr));
            for (int k = 0; k < 4; k++) begin
                if (flags[k] !== want.flags[k]) begin
                    miss(flag_name[k], t_u64'(want.flags[k]), t_u64'(flags[k]));
                end
            end
        endfunction

        function int pending();
            return waiting.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // [23:0] frame, [35:24] sample, [38:36] remainder, [70:39] wall_second, [71] zero
    logic [71:0]         s_axis_tdata;
    // [0] mode
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [63:0] timestamp_ns, [95:64] corrected_frame
    logic [95:0]         m_axis_tdata;
    // [0] rollover_fixed, [1] warn_backward, [2] warn_forward, [3] warn_near_pps
    logic [3:0]          m_axis_tuser;
    logic                i_cfg_we;
    logic [0:0]          i_cfg_idx;
    logic [26:0]         i_cfg_data;

    t_stamp_board                 board = new();
    logic                         no_idle;
    logic [prtt_pkg::FRAME_W-1:0] run_frame;
    logic [prtt_pkg::SEC_W-1:0]   run_second;

    pps_referenced_trigger_timestamp DUT (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_time_req pps_req(logic [prtt_pkg::FRAME_W-1:0] frm,
                                          logic [prtt_pkg::SAMPLE_W-1:0] smp,
                                          logic [prtt_pkg::REM_W-1:0] rm,
                                          logic [prtt_pkg::SEC_W-1:0] sec);
        t_time_req r;
        r.mode   = prtt_pkg::MODE_PPS;
        r.frame  = frm;
        r.sample = smp;
        r.rem    = rm;
        r.wsec   = sec;
        return r;
    endfunction

    function automatic t_time_req trig_req(logic [prtt_pkg::FRAME_W-1:0] frm,
                                           logic [prtt_pkg::SAMPLE_W-1:0] smp,
                                           logic [prtt_pkg::REM_W-1:0] rm);
        t_time_req r;
        r.mode   = prtt_pkg::MODE_TRIG;
        r.frame  = frm;
        r.sample = smp;
        r.rem    = rm;
        r.wsec   = prtt_pkg::SEC_W'($urandom);
        return r;
    endfunction

    // Mostly a running clock with PPS marks and triggers trailing them; the rest is noise.
    function automatic t_time_req next_random_req();
        t_time_req r;
        int        pick;
        pick     = $urandom_range(0, 99);
        r.mode   = 1'($urandom);
        r.frame  = prtt_pkg::FRAME_W'($urandom);
        r.sample = prtt_pkg::SAMPLE_W'($urandom);
        r.rem    = prtt_pkg::REM_W'($urandom);
        r.wsec   = prtt_pkg::SEC_W'($urandom);
        if (pick < 80) begin
            run_frame = run_frame + prtt_pkg::FRAME_W'($urandom_range(0, 600));
            r.frame   = run_frame;
            if (pick < 15) begin
                run_second = run_second + 32'd1;
                r.mode     = prtt_pkg::MODE_PPS;
                r.wsec     = run_second;
            end else begin
                r.mode = prtt_pkg::MODE_TRIG;
            end
        end
        return r;
    endfunction

    task automatic offer(t_time_req r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {1'b0, r.wsec, r.rem, r.sample, r.frame};
        s_axis_tuser  = r.mode;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(r);
    endtask

    // A PPS update leaves no result behind, so keep waiting after the last result, long enough
    // for a trigger to finish, before touching the registers.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [prtt_pkg::FTM_W-1:0] ftm, logic [prtt_pkg::FREQ_W-1:0] freq);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = prtt_pkg::CFG_FTM;
        i_cfg_data = prtt_pkg::FREQ_W'(ftm);
        @(negedge i_clk);
        i_cfg_idx  = prtt_pkg::CFG_FREQ;
        i_cfg_data = freq;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.write_reg(prtt_pkg::CFG_FTM, prtt_pkg::FREQ_W'(ftm));
        board.write_reg(prtt_pkg::CFG_FREQ, freq);
    endtask

    initial begin : result_sink
        int gap, taken;
        taken = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            // Long hold-offs keep the output register full, so a finished trigger waits in its flag step.
            if (taken == 25 || taken == 260) gap = 1500;
            @(negedge i_clk);
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_stamp(m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tuser);
            taken++;
        end
    end

    initial begin : stimulus
        logic [prtt_pkg::FTM_W-1:0]  ftm;
        logic [prtt_pkg::FREQ_W-1:0] freq;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = prtt_pkg::MODE_PPS;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = prtt_pkg::CFG_FTM;
        i_cfg_data    = '0;
        no_idle       = 1'b0;
        run_frame     = '0;
        run_second    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: trigger before any PPS, rollovers, wrap repair both ways,
        // backward and forward jumps, and no forward flag after a negative timestamp.
        offer(trig_req(24'd0, 12'd0, 3'd0));
        offer(pps_req(24'd100, 12'd5, 3'd3, 32'd1000));
        offer(trig_req(24'd100, 12'd5, 3'd3));
        offer(trig_req(24'd900, 12'hFFF, 3'd7));
        offer(trig_req(24'd50, 12'd0, 3'd0));
        offer(trig_req(24'hFFFFFF, 12'hFFF, 3'd7));
        offer(pps_req(24'd16777200, 12'd0, 3'd0, 32'hFFFFFFFF));
        offer(trig_req(24'd5, 12'd1, 3'd1));
        offer(pps_req(24'd0, 12'd0, 3'd0, 32'd10));
        offer(trig_req(24'd10, 12'd0, 3'd0));
        offer(pps_req(24'd0, 12'd0, 3'd0, 32'd100));
        offer(trig_req(24'd10, 12'd0, 3'd0));
        offer(pps_req(24'd1000, 12'd0, 3'd0, 32'd0));
        offer(trig_req(24'd0, 12'd0, 3'd0));
        offer(pps_req(24'd0, 12'd0, 3'd0, 32'd50));
        offer(trig_req(24'd10, 12'd0, 3'd0));

        // At 10 ns per tick the near-PPS limit falls between 99 and 100 ticks.
        drain();
        set_regs(16'hFFFF, 27'd100000000);
        offer(pps_req(24'd0, 12'd0, 3'd0, 32'd7));
        offer(trig_req(24'd0, 12'd12, 3'd3));
        offer(trig_req(24'd0, 12'd12, 3'd4));
        offer(trig_req(24'hFFFFFF, 12'hFFF, 3'd7));

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin ftm = 16'hFFFF; freq = 27'd100000000; end
                1: begin ftm = 16'd1;    freq = 27'd1000000;   end
                2: begin ftm = 16'd0;    freq = 27'd0;         end
                3: begin ftm = 16'hFFFF; freq = 27'h7FFFFFF;   end
                4: begin ftm = 16'd20479; freq = 27'd15999907; end
                default: begin
                    ftm  = prtt_pkg::FTM_W'($urandom);
                    freq = prtt_pkg::FREQ_W'($urandom_range(1000000, 100000000));
                end
            endcase
            if (p != 0) begin
                drain();
                set_regs(ftm, freq);
            end
            run_second = prtt_pkg::SEC_W'($urandom);
            if ($urandom_range(0, 2) == 0) begin
                run_frame = prtt_pkg::FRAME_W'(24'hFFFFFF - $urandom_range(0, 20000));
            end else begin
                run_frame = prtt_pkg::FRAME_W'($urandom);
            end
            for (int i = 0; i < 75; i++) begin
                no_idle = (i % 50) >= 38;
                offer(next_random_req());
            end
        end

        no_idle = 1'b0;
        drain();
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #6000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/prtt_pkg.sv
rtl/prtt_scale.sv
rtl/prtt_div.sv
rtl/pps_referenced_trigger_timestamp.sv
tb/tb_pps_referenced_trigger_timestamp.sv
